>>> sv/fdsa_pkg.sv
// Shared constants, codes and controller/datapath interface types for the sector allocator.
package fdsa_pkg;

   localparam int ENTRIES     = 16;
   localparam int ENTRY_BYTES = 32;
   localparam int NAME_BYTES  = 6;
   localparam int SLOTS       = 26;
   localparam int MAP_SECTORS = 256;
   localparam int DIR_SIZE    = ENTRIES * ENTRY_BYTES;

   localparam int ENT_W  = $clog2(ENTRIES);
   localparam int BYTE_W = $clog2(ENTRY_BYTES);
   localparam int DIR_W  = $clog2(DIR_SIZE);
   localparam int MAP_W  = $clog2(MAP_SECTORS);
   localparam int SLOT_W = $clog2(SLOTS + 1);
   localparam int SCAN_W = MAP_W + 1;
   localparam int NIDX_W = $clog2(NAME_BYTES + 1);

   localparam logic [2:0] OP_LOAD_DIR = 3'd0;
   localparam logic [2:0] OP_LOAD_MAP = 3'd1;
   localparam logic [2:0] OP_FIND     = 3'd2;
   localparam logic [2:0] OP_DELETE   = 3'd3;
   localparam logic [2:0] OP_WRITE    = 3'd4;

   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_NOT_FOUND = 2'd1;
   localparam logic [1:0] ST_DIR_FULL  = 2'd2;
   localparam logic [1:0] ST_DISK_FULL = 2'd3;

   typedef enum logic [4:0] {
      CMD_NONE,
      CMD_CLEAR,
      CMD_ACCEPT,
      CMD_FRD,
      CMD_FNEXT_BYTE,
      CMD_FNEXT_ENT,
      CMD_FEMPTY,
      CMD_RESULT,
      CMD_SRD,
      CMD_DFREE,
      CMD_DEND,
      CMD_LSTORE,
      CMD_LDONE,
      CMD_TRIM,
      CMD_ARD,
      CMD_ATAKE,
      CMD_WNAME,
      CMD_MARK,
      CMD_WRES,
      CMD_NEXT
   } cmd_code_type;

   typedef struct packed {
      cmd_code_type code;
      logic [1:0]   res_status;
      logic         res_use_ent;
   } cmd_type;

   typedef struct packed {
      logic       clr_last;
      logic       match;
      logic       byte_end;
      logic       ent_last;
      logic       empty;
      logic [2:0] op;
      logic       k_end;
      logic       rd_zero;
      logic       trim;
      logic       alloc_done;
      logic       w_last;
      logic       mark_done;
      logic       rsp_last;
   } stat_type;

   // Name byte i of a packed name, zero for i at or past NAME_BYTES.
   function automatic logic [7:0] name_byte(input logic [8*NAME_BYTES-1:0] name,
                                            input logic [NIDX_W-1:0] i);
      logic [7:0] b;
      b = 8'd0;
      for (int j = 0; j < NAME_BYTES; j++) begin
         if (i == NIDX_W'(j)) b = name[8*j +: 8];
      end
      return b;
   endfunction

endpackage

>>> sv/fdsa_datapath.sv
// Datapath: directory and map memories, scan counters, sector list and result registers.
module fdsa_datapath (
   input  logic                       clock,
   input  logic                       reset,
   input  fdsa_pkg::cmd_type          cmd,
   output fdsa_pkg::stat_type         st,
   input  logic [2:0]                 req_op,
   input  logic [47:0]                req_file_name,
   input  logic [4:0]                 req_sector_count,
   input  logic [8:0]                 req_load_index,
   input  logic [7:0]                 req_load_value,
   output logic [1:0]                 rsp_status,
   output logic [3:0]                 rsp_entry_index,
   output logic [7:0]                 rsp_sector_number,
   output logic                       rsp_last
);
   import fdsa_pkg::*;

   logic [7:0]        dir_mem [DIR_SIZE];
   logic              map_mem [MAP_SECTORS];
   logic [7:0]        dir_rd_ff;
   logic              map_rd_ff;

   logic [DIR_W-1:0]  clr_ff;
   logic [2:0]        op_ff;
   logic [47:0]       name_ff;
   logic [SLOT_W-1:0] req_ff;
   logic [ENT_W-1:0]  ent_ff;
   logic [NIDX_W-1:0] i_ff;
   logic              empty_ff;
   logic [SLOT_W-1:0] k_ff;
   logic [SLOT_W-1:0] n_ff;
   logic [SCAN_W-1:0] s_ff;
   logic [BYTE_W-1:0] w_ff;
   logic              zero_ff;
   logic [7:0]        list_ff [SLOTS];
   logic [1:0]        res_status_ff;
   logic [ENT_W-1:0]  res_entry_ff;
   logic              listmode_ff;

   logic              dir_we, map_we, map_wd;
   logic [DIR_W-1:0]  dir_wa, dir_ra;
   logic [7:0]        dir_wd;
   logic [MAP_W-1:0]  map_wa;
   logic [7:0]        target;
   logic [BYTE_W-1:0] slot_off;
   logic [7:0]        wname_c;
   logic [SLOT_W-1:0] wk;
   logic [SLOT_W-1:0] n_m1;

   assign target   = empty_ff ? 8'd0 : name_byte(name_ff, i_ff);
   assign slot_off = BYTE_W'(NAME_BYTES) + BYTE_W'(k_ff);
   assign wname_c  = name_byte(name_ff, NIDX_W'(w_ff < BYTE_W'(NAME_BYTES) ? w_ff : '0));
   assign wk       = SLOT_W'(w_ff - BYTE_W'(NAME_BYTES));
   assign n_m1     = n_ff - SLOT_W'(1);

   always_comb begin
      dir_ra = {ent_ff, slot_off};
      if (cmd.code == CMD_FRD) dir_ra = {ent_ff, BYTE_W'(i_ff)};
   end

   // Write port selection
   always_comb begin
      dir_we = 1'b0; dir_wa = {ent_ff, w_ff}; dir_wd = 8'd0;
      map_we = 1'b0; map_wa = '0; map_wd = 1'b0;
      unique case (cmd.code)
         CMD_CLEAR: begin
            dir_we = 1'b1; dir_wa = clr_ff;
            map_we = 1'b1; map_wa = clr_ff[MAP_W-1:0];
         end
         CMD_ACCEPT: begin
            if (req_op == OP_LOAD_DIR) begin
               dir_we = 1'b1; dir_wa = req_load_index; dir_wd = req_load_value;
            end
            if (req_op == OP_LOAD_MAP && req_load_index < 9'(MAP_SECTORS)) begin
               map_we = 1'b1; map_wa = req_load_index[MAP_W-1:0];
               map_wd = (req_load_value != 8'd0);
            end
         end
         CMD_DFREE: begin
            map_we = 1'b1; map_wa = dir_rd_ff;
         end
         CMD_DEND: begin
            dir_we = 1'b1; dir_wa = {ent_ff, BYTE_W'(0)};
         end
         CMD_TRIM: begin
            map_we = 1'b1; map_wa = list_ff[n_m1];
         end
         CMD_WNAME: begin
            dir_we = 1'b1;
            if (w_ff < BYTE_W'(NAME_BYTES))
               dir_wd = (zero_ff || wname_c == 8'd0) ? 8'd0 : wname_c;
            else
               dir_wd = (wk < n_ff) ? list_ff[wk] : 8'd0;
         end
         CMD_MARK: begin
            map_we = 1'b1; map_wa = list_ff[k_ff]; map_wd = 1'b1;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (dir_we) dir_mem[dir_wa] <= dir_wd;
      dir_rd_ff <= dir_mem[dir_ra];
      if (map_we) map_mem[map_wa] <= map_wd;
      map_rd_ff <= map_mem[s_ff[MAP_W-1:0]];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff <= '0;
      end else begin
         unique case (cmd.code)
            CMD_CLEAR: clr_ff <= clr_ff + DIR_W'(1);
            CMD_ACCEPT: begin
               op_ff        <= req_op;
               name_ff      <= req_file_name;
               req_ff       <= (req_sector_count > 5'(SLOTS)) ? SLOT_W'(SLOTS)
                                                               : SLOT_W'(req_sector_count);
               ent_ff       <= '0;
               i_ff         <= '0;
               empty_ff     <= 1'b0;
               k_ff         <= '0;
               n_ff         <= '0;
               s_ff         <= SCAN_W'(1);
               w_ff         <= '0;
               zero_ff      <= 1'b0;
               res_status_ff <= ST_OK;
               res_entry_ff <= '0;
               listmode_ff  <= 1'b0;
            end
            CMD_FNEXT_BYTE: i_ff <= i_ff + NIDX_W'(1);
            CMD_FNEXT_ENT: begin
               ent_ff <= ent_ff + ENT_W'(1);
               i_ff   <= '0;
            end
            CMD_FEMPTY: begin
               empty_ff <= 1'b1; ent_ff <= '0; i_ff <= '0;
            end
            CMD_RESULT: begin
               res_status_ff <= cmd.res_status;
               res_entry_ff  <= cmd.res_use_ent ? ent_ff : '0;
            end
            CMD_DFREE: k_ff <= k_ff + SLOT_W'(1);
            CMD_DEND: begin
               res_status_ff <= ST_OK;
               res_entry_ff  <= ent_ff;
            end
            CMD_LSTORE: begin
               list_ff[k_ff] <= dir_rd_ff;
               k_ff          <= k_ff + SLOT_W'(1);
            end
            CMD_LDONE: n_ff <= k_ff;
            CMD_TRIM:  n_ff <= n_m1;
            CMD_ATAKE: begin
               if (!map_rd_ff) begin
                  list_ff[n_ff] <= s_ff[MAP_W-1:0];
                  n_ff          <= n_ff + SLOT_W'(1);
               end
               s_ff <= s_ff + SCAN_W'(1);
            end
            CMD_WNAME: begin
               if (w_ff < BYTE_W'(NAME_BYTES) && wname_c == 8'd0) zero_ff <= 1'b1;
               w_ff <= w_ff + BYTE_W'(1);
               k_ff <= '0;
            end
            CMD_MARK: k_ff <= k_ff + SLOT_W'(1);
            CMD_WRES: begin
               res_status_ff <= (n_ff < req_ff) ? ST_DISK_FULL : ST_OK;
               res_entry_ff  <= ent_ff;
               listmode_ff   <= 1'b1;
               k_ff          <= '0;
            end
            CMD_NEXT: k_ff <= k_ff + SLOT_W'(1);
            default: ;
         endcase
      end
   end

   assign st.clr_last   = (clr_ff == DIR_W'(DIR_SIZE - 1));
   assign st.match      = (dir_rd_ff == target);
   assign st.byte_end   = (target == 8'd0) || (i_ff == NIDX_W'(NAME_BYTES - 1));
   assign st.ent_last   = (ent_ff == ENT_W'(ENTRIES - 1));
   assign st.empty      = empty_ff;
   assign st.op         = op_ff;
   assign st.k_end      = (k_ff == SLOT_W'(SLOTS));
   assign st.rd_zero    = (dir_rd_ff == 8'd0);
   assign st.trim       = (n_ff > req_ff);
   assign st.alloc_done = (s_ff == SCAN_W'(MAP_SECTORS)) || (n_ff >= req_ff);
   assign st.w_last     = (w_ff == BYTE_W'(ENTRY_BYTES - 1));
   assign st.mark_done  = (k_ff >= n_ff);
   assign st.rsp_last   = !listmode_ff || n_ff == '0 || k_ff == n_m1;

   assign rsp_status        = res_status_ff;
   assign rsp_entry_index   = res_entry_ff;
   assign rsp_sector_number = (listmode_ff && n_ff != '0) ? list_ff[k_ff] : 8'd0;
   assign rsp_last          = st.rsp_last;

endmodule

>>> sv/fdsa_ctrl.sv
// Controller: sequences the clearing pass, name search, delete, write and result beats.
module fdsa_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic [2:0]         req_op,
   output logic               req_ready,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   input  fdsa_pkg::stat_type st,
   output fdsa_pkg::cmd_type  cmd
);
   import fdsa_pkg::*;

   typedef enum logic [3:0] {
      S_CLEAR, S_IDLE, S_FRD, S_FCMP, S_DRD, S_DCHK, S_DEND, S_LRD, S_LCHK,
      S_TRIM, S_ARD, S_ACHK, S_WNAME, S_MARK, S_OUT
   } state_type;

   state_type state_ff, state_in;
   logic      req_ready_ff, rsp_valid_ff;

   always_comb begin
      state_in        = state_ff;
      cmd.code        = CMD_NONE;
      cmd.res_status  = ST_OK;
      cmd.res_use_ent = 1'b0;
      unique case (state_ff)
         S_CLEAR: begin
            cmd.code = CMD_CLEAR;
            if (st.clr_last) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (req_valid) begin
               cmd.code = CMD_ACCEPT;
               if (req_op == OP_FIND || req_op == OP_DELETE || req_op == OP_WRITE)
                  state_in = S_FRD;
               else
                  state_in = S_OUT;
            end
         end
         S_FRD: begin
            cmd.code = CMD_FRD;
            state_in = S_FCMP;
         end
         S_FCMP: begin
            if (st.match && st.byte_end) begin
               if (st.op == OP_FIND) begin
                  cmd.code = CMD_RESULT; cmd.res_use_ent = 1'b1;
                  state_in = S_OUT;
               end else if (st.op == OP_DELETE) state_in = S_DRD;
               else if (st.empty) state_in = S_ARD;
               else state_in = S_LRD;
            end else if (st.match) begin
               cmd.code = CMD_FNEXT_BYTE; state_in = S_FRD;
            end else if (!st.ent_last) begin
               cmd.code = CMD_FNEXT_ENT; state_in = S_FRD;
            end else if (st.op != OP_WRITE) begin
               cmd.code = CMD_RESULT; cmd.res_status = ST_NOT_FOUND;
               state_in = S_OUT;
            end else if (!st.empty) begin
               cmd.code = CMD_FEMPTY; state_in = S_FRD;
            end else begin
               cmd.code = CMD_RESULT; cmd.res_status = ST_DIR_FULL;
               state_in = S_OUT;
            end
         end
         S_DRD: begin
            if (st.k_end) state_in = S_DEND;
            else begin
               cmd.code = CMD_SRD; state_in = S_DCHK;
            end
         end
         S_DCHK: begin
            if (st.rd_zero) state_in = S_DEND;
            else begin
               cmd.code = CMD_DFREE; state_in = S_DRD;
            end
         end
         S_DEND: begin
            cmd.code = CMD_DEND; state_in = S_OUT;
         end
         S_LRD: begin
            if (st.k_end) begin
               cmd.code = CMD_LDONE; state_in = S_TRIM;
            end else begin
               cmd.code = CMD_SRD; state_in = S_LCHK;
            end
         end
         S_LCHK: begin
            if (st.rd_zero) begin
               cmd.code = CMD_LDONE; state_in = S_TRIM;
            end else begin
               cmd.code = CMD_LSTORE; state_in = S_LRD;
            end
         end
         S_TRIM: begin
            if (st.trim) cmd.code = CMD_TRIM;
            else state_in = S_ARD;
         end
         S_ARD: begin
            if (st.alloc_done) state_in = S_WNAME;
            else begin
               cmd.code = CMD_ARD; state_in = S_ACHK;
            end
         end
         S_ACHK: begin
            cmd.code = CMD_ATAKE; state_in = S_ARD;
         end
         S_WNAME: begin
            cmd.code = CMD_WNAME;
            if (st.w_last) state_in = S_MARK;
         end
         S_MARK: begin
            if (st.mark_done) begin
               cmd.code = CMD_WRES; state_in = S_OUT;
            end else cmd.code = CMD_MARK;
         end
         S_OUT: begin
            if (rsp_ready) begin
               if (st.rsp_last) state_in = S_IDLE;
               else cmd.code = CMD_NEXT;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         req_ready_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         req_ready_ff <= (state_in == S_IDLE);
         rsp_valid_ff <= (state_in == S_OUT);
      end
   end

   assign req_ready = req_ready_ff;
   assign rsp_valid = rsp_valid_ff;

   a_excl: assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid)) else $error("ready and result valid together");
   a_acc: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready) else $error("second beat taken while busy");
   a_done: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && st.rsp_last |=> req_ready && !rsp_valid)
      else $error("not idle after final result");
   a_clr: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_CLEAR |-> !req_ready && !rsp_valid) else $error("busy during clear");

endmodule

>>> sv/file_directory_sector_allocator_unit.sv
// Top level of the file directory and sector allocator.
// Usage:
//  - Request channel (req_*): one beat per operation: load directory byte, load
//    map flag, find, delete or write. Handshake is valid/ready.
//  - Result channel (rsp_*): one beat per result; rsp_last marks the final beat
//    of an operation. A write gives one beat per listed sector (one beat if none).
//  - Operations run one at a time; req_ready is low from acceptance until the
//    final result beat has been taken.
//  - Sequencing: loads and unused op codes show their result the cycle after
//    acceptance; no new request is taken until that beat has been taken.
//    Find/delete compare the name byte by byte (up to 16 x 6 bytes), with a read
//    and a compare step per byte; delete then frees each listed sector; a write
//    reads the slots of an existing entry, frees surplus sectors, scans map
//    sectors (up to 255) for free ones, rewrites the 32-byte entry and marks
//    each listed sector. The directory memory has a single read port.
//  - Reset: synchronous, active high. A clearing pass then zeroes the 512-byte
//    directory and the 256-entry map, with req_ready held low.
//  - Stall: a result beat holds on the port until rsp_ready; the operation
//    waits with it.
module file_directory_sector_allocator_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [2:0]  req_op,
   input  logic [47:0] req_file_name,
   input  logic [4:0]  req_sector_count,
   input  logic [8:0]  req_load_index,
   input  logic [7:0]  req_load_value,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_status,
   output logic [3:0]  rsp_entry_index,
   output logic [7:0]  rsp_sector_number,
   output logic        rsp_last
);
   import fdsa_pkg::*;

   cmd_type  cmd;
   stat_type st;

   // sequencing
   fdsa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_op    (req_op),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .st        (st),
      .cmd       (cmd)
   );

   // storage and result beats
   fdsa_datapath u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .st                (st),
      .req_op            (req_op),
      .req_file_name     (req_file_name),
      .req_sector_count  (req_sector_count),
      .req_load_index    (req_load_index),
      .req_load_value    (req_load_value),
      .rsp_status        (rsp_status),
      .rsp_entry_index   (rsp_entry_index),
      .rsp_sector_number (rsp_sector_number),
      .rsp_last          (rsp_last)
   );

endmodule
